// ===== rtl/sdm_pkg.sv =====
// Shared types, constants and helper functions of the service deadline monitor.
`timescale 1ns / 1ps
`default_nettype none
package sdm_pkg;

    localparam int VOICES = 8;
    localparam int VIDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;

    localparam int IN_DATA_W  = 168;
    localparam int IN_USER_W  = 4;
    localparam int OUT_DATA_W = 360;

    localparam logic [31:0] ALL32 = 32'hFFFF_FFFF;
    localparam logic [63:0] ALL64 = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [7:0]  NO_VOICE = 8'd255;

    typedef enum logic [2:0] {
        FN_SELECT    = 3'd0,
        FN_UNDERRUN  = 3'd1,
        FN_ROUND_BEG = 3'd2,
        FN_ROUND_END = 3'd3,
        FN_IO_DONE   = 3'd4,
        FN_CLEAR     = 3'd5
    } t_func;

    typedef struct packed {
        logic [2:0]  func;
        logic [7:0]  voice;
        logic [31:0] now_frame;
        logic [31:0] deadline_frame;
        logic [31:0] underrun_page;
        logic [31:0] cycle_stamp;
        logic        read_backend;
        logic [31:0] read_count;
    } t_evt;

    typedef struct packed {
        logic adv;
        logic en;
    } t_ctl;

    typedef struct packed {
        logic [31:0] last_frame;
        logic        last_valid;
    } t_vrd;

    typedef struct packed {
        logic [31:0] min_margin;
        logic [31:0] max_gap;
        logic [31:0] underrun_count;
        logic [7:0]  fault_voice_id;
        logic [31:0] fault_page_id;
        logic [31:0] round_count;
        logic [31:0] round_cycles_peak;
        logic [63:0] round_cycles_total;
        logic [31:0] contig_reads;
        logic [31:0] filesystem_reads;
    } t_stats;

    function automatic logic f_voice_ok(input logic [7:0] voice);
        return voice < 8'(VOICES);
    endfunction

    function automatic logic [31:0] f_margin(input logic [31:0] now_frame,
                                             input logic [31:0] deadline_frame);
        return (deadline_frame > now_frame) ? (deadline_frame - now_frame) : 32'd0;
    endfunction

    function automatic logic [31:0] f_sat_add32(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? ALL32 : s[31:0];
    endfunction

endpackage
`default_nettype wire

// ===== rtl/sdm_in_stage.sv =====
// Input register stage: takes one event transaction and holds it until it advances.
`timescale 1ns / 1ps
`default_nettype none
module sdm_in_stage import sdm_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire logic [IN_DATA_W-1:0] i_data,
    input  wire logic [IN_USER_W-1:0] i_user,
    input  wire logic                 i_take,
    output logic                      o_valid,
    output t_evt                      o_evt
);

    logic r_valid;
    t_evt r_evt;
    t_evt n_evt;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_evt   = r_evt;

    always_comb begin
        n_evt.func           = i_user[2:0];
        n_evt.read_backend   = i_user[3];
        n_evt.voice          = i_data[7:0];
        n_evt.now_frame      = i_data[39:8];
        n_evt.deadline_frame = i_data[71:40];
        n_evt.underrun_page  = i_data[103:72];
        n_evt.cycle_stamp    = i_data[135:104];
        n_evt.read_count     = i_data[167:136];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_evt <= n_evt;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/sdm_voice_table.sv =====
// Per-voice table: last service frame, valid bit and minimum margin of each voice.
`timescale 1ns / 1ps
`default_nettype none
module sdm_voice_table import sdm_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_ctl  i_ctl,
    input  wire t_evt  i_evt,
    output t_vrd       o_rd,
    output logic [31:0] o_vmin
);

    logic [31:0]       r_frame [VOICES];
    logic [VOICES-1:0] r_valid;
    logic [31:0]       r_vmin  [VOICES];
    logic [31:0]       r_res_vmin;

    logic              w_ok;
    logic [VIDX_W-1:0] w_idx;
    logic              w_sel;
    logic              w_clr;
    logic [31:0]       w_margin;
    logic [31:0]       w_vmin_cur;
    logic [31:0]       w_vmin_new;

    assign w_ok       = f_voice_ok(i_evt.voice);
    assign w_idx      = i_evt.voice[VIDX_W-1:0];
    assign w_sel      = i_ctl.en && (i_evt.func == FN_SELECT) && w_ok;
    assign w_clr      = i_ctl.en && (i_evt.func == FN_CLEAR);
    assign w_margin   = f_margin(i_evt.now_frame, i_evt.deadline_frame);
    assign w_vmin_cur = r_vmin[w_idx];
    assign w_vmin_new = (w_sel && (w_margin < w_vmin_cur)) ? w_margin : w_vmin_cur;

    assign o_rd.last_frame = r_frame[w_idx];
    assign o_rd.last_valid = r_valid[w_idx];
    assign o_vmin          = r_res_vmin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_res_vmin <= ALL32;
            for (int i = 0; i < VOICES; i++) begin
                r_vmin[i] <= ALL32;
            end
        end else if (i_ctl.adv) begin
            if (w_clr) begin
                r_valid <= '0;
                for (int i = 0; i < VOICES; i++) begin
                    r_vmin[i] <= ALL32;
                end
            end else if (w_sel) begin
                r_valid[w_idx] <= 1'b1;
                r_vmin[w_idx]  <= w_vmin_new;
            end
            r_res_vmin <= (w_clr || !w_ok) ? ALL32 : w_vmin_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv) begin
            if (w_sel) begin
                r_frame[w_idx] <= i_evt.now_frame;
            end
        end
    end

endmodule
`default_nettype wire

// ===== rtl/sdm_stats.sv =====
// Global statistics: margins, gaps, underruns, rounds and read counters.
`timescale 1ns / 1ps
`default_nettype none
module sdm_stats import sdm_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_ctl i_ctl,
    input  wire t_evt i_evt,
    input  wire t_vrd i_vrd,
    output t_stats    o_stats
);

    t_stats      r_st;
    t_stats      n_st;
    logic [31:0] r_round_start;
    logic [31:0] n_round_start;
    logic        r_round_sel;
    logic        n_round_sel;

    logic        w_ok;
    logic [31:0] w_margin;
    logic [31:0] w_gap;
    logic [31:0] w_cyc;
    logic [64:0] w_sum;

    assign w_ok     = f_voice_ok(i_evt.voice);
    assign w_margin = f_margin(i_evt.now_frame, i_evt.deadline_frame);
    assign w_gap    = i_evt.now_frame - i_vrd.last_frame;
    assign w_cyc    = i_evt.cycle_stamp - r_round_start;
    assign w_sum    = {1'b0, r_st.round_cycles_total} + {33'd0, w_cyc};
    assign o_stats  = r_st;

    always_comb begin
        n_st          = r_st;
        n_round_start = r_round_start;
        n_round_sel   = r_round_sel;
        if (i_ctl.en) begin
            case (i_evt.func)
                FN_SELECT: begin
                    if (w_ok) begin
                        n_round_sel = 1'b1;
                        if (w_margin < r_st.min_margin) begin
                            n_st.min_margin = w_margin;
                        end
                        if (i_vrd.last_valid && (w_gap > r_st.max_gap)) begin
                            n_st.max_gap = w_gap;
                        end
                    end
                end
                FN_UNDERRUN: begin
                    n_st.underrun_count = f_sat_add32(r_st.underrun_count, 32'd1);
                    n_st.min_margin     = 32'd0;
                    if (r_st.fault_voice_id == NO_VOICE) begin
                        n_st.fault_voice_id = w_ok ? i_evt.voice : NO_VOICE;
                        n_st.fault_page_id  = i_evt.underrun_page;
                    end
                end
                FN_ROUND_BEG: begin
                    n_round_start = i_evt.cycle_stamp;
                    n_round_sel   = 1'b0;
                end
                FN_ROUND_END: begin
                    if (r_round_sel) begin
                        n_st.round_cycles_total = w_sum[64] ? ALL64 : w_sum[63:0];
                        n_st.round_count = f_sat_add32(r_st.round_count, 32'd1);
                        if (w_cyc > r_st.round_cycles_peak) begin
                            n_st.round_cycles_peak = w_cyc;
                        end
                    end
                end
                FN_IO_DONE: begin
                    if (i_evt.read_backend) begin
                        n_st.contig_reads =
                            f_sat_add32(r_st.contig_reads, i_evt.read_count);
                    end else begin
                        n_st.filesystem_reads =
                            f_sat_add32(r_st.filesystem_reads, i_evt.read_count);
                    end
                end
                FN_CLEAR: begin
                    n_st.min_margin         = ALL32;
                    n_st.max_gap            = 32'd0;
                    n_st.underrun_count     = 32'd0;
                    n_st.fault_voice_id     = NO_VOICE;
                    n_st.fault_page_id      = ALL32;
                    n_st.round_count        = 32'd0;
                    n_st.round_cycles_peak  = 32'd0;
                    n_st.round_cycles_total = 64'd0;
                    n_st.contig_reads       = 32'd0;
                    n_st.filesystem_reads   = 32'd0;
                    n_round_sel             = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st.min_margin         <= ALL32;
            r_st.max_gap            <= 32'd0;
            r_st.underrun_count     <= 32'd0;
            r_st.fault_voice_id     <= NO_VOICE;
            r_st.fault_page_id      <= ALL32;
            r_st.round_count        <= 32'd0;
            r_st.round_cycles_peak  <= 32'd0;
            r_st.round_cycles_total <= 64'd0;
            r_st.contig_reads       <= 32'd0;
            r_st.filesystem_reads   <= 32'd0;
            r_round_start           <= 32'd0;
            r_round_sel             <= 1'b0;
        end else if (i_ctl.adv) begin
            r_st          <= n_st;
            r_round_start <= n_round_start;
            r_round_sel   <= n_round_sel;
        end
    end

    a_fault_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st.fault_voice_id != NO_VOICE) |-> (r_st.underrun_count != 32'd0))
        else $error("fault voice recorded without an underrun");

    a_rounds_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st.round_count == 32'd0) |->
            ((r_st.round_cycles_total == 64'd0) && (r_st.round_cycles_peak == 32'd0)))
        else $error("round cycles accumulated without a counted round");

endmodule
`default_nettype wire

// ===== rtl/service_deadline_monitor.sv =====
// Top level of the service deadline monitor: handshake, enable register and result port.
`timescale 1ns / 1ps
`default_nettype none
// One event transaction in, one statistics transaction out. An event is taken into an input
// register and, when it advances, updates the per-voice table and the global statistics
// while its result is loaded into the output register; events flow at one per cycle while the
// output is not held, and o_m_tvalid is set as the event advances. The output register and
// the input register let a new event be taken while a result waits for i_m_tready. The result
// is the statistics after the event; voice_min_margin is that of the event's voice, all ones
// for a voice at or above the voice count. Clearing monitor_enable makes events leave all
// statistics unchanged; each event still returns a result. Write the enable only while idle.
module service_deadline_monitor import sdm_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic                  i_cfg_data,     // monitor_enable
    input  wire logic                  i_s_tvalid,
    output logic                       o_s_tready,
    // voice[7:0], now_frame[39:8], deadline_frame[71:40], underrun_page[103:72],
    // cycle_stamp[135:104], read_count[167:136]
    input  wire logic [IN_DATA_W-1:0]  i_s_tdata,
    // func[2:0], read_backend[3]
    input  wire logic [IN_USER_W-1:0]  i_s_tuser,
    output logic                       o_m_tvalid,
    input  wire logic                  i_m_tready,
    // min_margin[31:0], voice_min_margin[63:32], max_gap[95:64], underrun_count[127:96],
    // fault_voice_id[135:128], fault_page_id[167:136], round_count[199:168],
    // round_cycles_peak[231:200], round_cycles_total[295:232], contig_reads[327:296],
    // filesystem_reads[359:328]
    output logic [OUT_DATA_W-1:0]      o_m_tdata
);

    logic        r_enable;
    logic        r_out_valid;
    logic        w_in_valid;
    logic        w_adv;
    t_evt        w_evt;
    t_ctl        w_ctl;
    t_vrd        w_vrd;
    t_stats      w_st;
    logic [31:0] w_vmin;

    assign o_cfg_ready = 1'b1;
    assign w_adv       = w_in_valid && (!r_out_valid || i_m_tready);
    assign w_ctl.adv   = w_adv;
    assign w_ctl.en    = r_enable;
    assign o_m_tvalid  = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable    <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_enable <= i_cfg_data;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    sdm_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_data  (i_s_tdata),
        .i_user  (i_s_tuser),
        .i_take  (w_adv),
        .o_valid (w_in_valid),
        .o_evt   (w_evt)
    );

    sdm_voice_table u_voice (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_evt   (w_evt),
        .o_rd    (w_vrd),
        .o_vmin  (w_vmin)
    );

    sdm_stats u_stats (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_evt   (w_evt),
        .i_vrd   (w_vrd),
        .o_stats (w_st)
    );

    assign o_m_tdata = {w_st.filesystem_reads, w_st.contig_reads,
                        w_st.round_cycles_total, w_st.round_cycles_peak, w_st.round_count,
                        w_st.fault_page_id, w_st.fault_voice_id, w_st.underrun_count,
                        w_st.max_gap, w_vmin, w_st.min_margin};

    a_full_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_valid && r_out_valid && !i_m_tready) |-> !o_s_tready)
        else $error("input taken while both stages are held");

    a_hold_stats: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && !w_adv) |=> $stable(o_m_tdata))
        else $error("statistics changed without an event advancing");

endmodule
`default_nettype wire
